// File: rtl/midpoint_ellipse_raster_defines.svh
// assertion macros shared by the ellipse rasterizer modules
`ifndef MIDPOINT_ELLIPSE_RASTER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MER_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ellipse raster check failed");

// consequent checked in the cycle after the antecedent
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ellipse raster check failed");

`endif

// File: rtl/mer_pkg.sv
// shared types and constants of the midpoint ellipse rasterizer
`default_nettype none

package mer_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 12;

    // input item kinds, carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [3:0] {
        ST_READY,
        ST_INIT_RX2,
        ST_INIT_RY2,
        ST_INIT_SLOPE,
        ST_INIT_LOAD,
        ST_RC_TX,
        ST_RC_TY,
        ST_RC_A,
        ST_RC_B,
        ST_RC_C,
        ST_RC_DONE,
        ST_STEP
    } t_state;

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RXRX,
        MUL_RYRY,
        MUL_RX2RY,
        MUL_TXTX,
        MUL_TYTY,
        MUL_RY2TA,
        MUL_RX2TB,
        MUL_RX2RY2
    } t_mul_sel;

    // destination of the registered product
    typedef enum logic [3:0] {
        WB_NONE,
        WB_RX2,
        WB_RY2,
        WB_INIT,
        WB_TA,
        WB_TB,
        WB_DEC_SET,
        WB_DEC_ADD,
        WB_DEC_SUB
    } t_wb;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_wb      wb;
        logic     latch_start;
        logic     step_fire;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic need_rc;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/mer_ctrl.sv
// controller state machine: start setup, region change sequence and step issue
`default_nettype none

`include "midpoint_ellipse_raster_defines.svh"

module mer_ctrl
    import mer_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_kind,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_READY: begin
                if (i_valid) begin
                    priority if (i_kind == KIND_START) n_state = ST_INIT_RX2;
                    else if (!i_status.busy)         n_state = ST_READY;
                    else if (i_status.need_rc)       n_state = ST_RC_TX;
                    else                             n_state = ST_STEP;
                end
            end
            ST_INIT_RX2:   n_state = ST_INIT_RY2;
            ST_INIT_RY2:   n_state = ST_INIT_SLOPE;
            ST_INIT_SLOPE: n_state = ST_INIT_LOAD;
            ST_INIT_LOAD:  n_state = ST_READY;
            ST_RC_TX:      n_state = ST_RC_TY;
            ST_RC_TY:      n_state = ST_RC_A;
            ST_RC_A:       n_state = ST_RC_B;
            ST_RC_B:       n_state = ST_RC_C;
            ST_RC_C:       n_state = ST_RC_DONE;
            ST_RC_DONE:    n_state = ST_STEP;
            ST_STEP: begin
                if (i_status.out_free) n_state = ST_READY;
            end
            default:       n_state = ST_READY;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '{mul_sel: MUL_NONE, wb: WB_NONE, latch_start: 1'b0, step_fire: 1'b0};
        unique case (r_state)
            ST_READY: begin
                o_ready           = 1'b1;
                o_cmd.latch_start = i_valid && (i_kind == KIND_START);
            end
            ST_INIT_RX2: o_cmd.mul_sel = MUL_RXRX;
            ST_INIT_RY2: begin
                o_cmd.mul_sel = MUL_RYRY;
                o_cmd.wb      = WB_RX2;
            end
            ST_INIT_SLOPE: begin
                o_cmd.mul_sel = MUL_RX2RY;
                o_cmd.wb      = WB_RY2;
            end
            ST_INIT_LOAD: o_cmd.wb = WB_INIT;
            ST_RC_TX:     o_cmd.mul_sel = MUL_TXTX;
            ST_RC_TY: begin
                o_cmd.mul_sel = MUL_TYTY;
                o_cmd.wb      = WB_TA;
            end
            ST_RC_A: begin
                o_cmd.mul_sel = MUL_RY2TA;
                o_cmd.wb      = WB_TB;
            end
            ST_RC_B: begin
                o_cmd.mul_sel = MUL_RX2TB;
                o_cmd.wb      = WB_DEC_SET;
            end
            ST_RC_C: begin
                o_cmd.mul_sel = MUL_RX2RY2;
                o_cmd.wb      = WB_DEC_ADD;
            end
            ST_RC_DONE: o_cmd.wb = WB_DEC_SUB;
            ST_STEP:    o_cmd.step_fire = i_status.out_free;
            default: ;
        endcase
    end

    `MER_ASSERT_NEXT(a_start_enters_setup, i_clk, i_rst_n, i_valid && o_ready && (i_kind == KIND_START), r_state == ST_INIT_RX2)
    `MER_ASSERT_NEXT(a_step_waits_on_output, i_clk, i_rst_n, (r_state == ST_STEP) && !i_status.out_free, r_state == ST_STEP)
    `MER_ASSERT_NEXT(a_region_change_to_step, i_clk, i_rst_n, r_state == ST_RC_DONE, r_state == ST_STEP)

endmodule

`default_nettype wire

// File: rtl/mer_datapath.sv
// datapath: held inputs, shared multiplier, offset and decision registers, result register
`default_nettype none

`include "midpoint_ellipse_raster_defines.svh"

module mer_datapath
    import mer_pkg::*;
#(
    parameter  int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter  int COORD_BITS  = COORD_BITS_DEF,
    localparam int IN_TD_W     = ((2 * RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TD_W    = ((4 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [IN_TD_W-1:0]  i_data,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OUT_TD_W-1:0]      o_data,
    output logic                     o_last
);

    localparam int R     = RADIUS_BITS;
    localparam int C     = COORD_BITS;
    localparam int OUT_W = C + 2;
    localparam int MW    = 2 * R + 2;
    localparam int PW    = 2 * MW;
    localparam int ST_W  = 3 * R + 4;
    localparam int DEC_W = 4 * R + 8;
    localparam int X_W   = R + 1;
    localparam int Y_W   = R + 2;
    localparam int EXT_W = ((OUT_W > Y_W) ? OUT_W : Y_W) + 1;

    logic [R-1:0]              r_rx, r_ry;
    logic [C-1:0]              r_cx, r_cy;
    logic [2*R-1:0]            r_rx2, r_ry2, n_rx2, n_ry2;
    logic [PW-1:0]             r_prod;
    logic [MW-1:0]             r_ta, r_tb, n_ta, n_tb;
    logic [X_W-1:0]            r_x, n_x;
    logic signed [Y_W-1:0]     r_y, n_y;
    logic signed [ST_W-1:0]    r_sx, r_sy, n_sx, n_sy;
    logic signed [DEC_W-1:0]   r_dec, n_dec;
    logic                      r_region2, n_region2;
    logic                      r_busy, n_busy;
    logic                      r_o_valid, n_o_valid;
    logic [OUT_TD_W-1:0]       r_o_data;
    logic                      r_o_last;

    logic [MW-1:0]             mul_a, mul_b;
    logic [PW-1:0]             mul_p;
    logic signed [Y_W:0]       ty_s;
    logic [Y_W:0]              ty_abs;

    // step update terms
    logic [X_W-1:0]            x_inc;
    logic signed [Y_W-1:0]     y_dec;
    logic signed [ST_W-1:0]    two_ry2, two_rx2, sx_inc, sy_dec;
    logic signed [DEC_W-1:0]   sx_inc_e, sy_dec_e, rx2_e, ry2_e, prod_e, term;
    logic signed [DEC_W-1:0]   init_dec;
    logic                      step_last;

    // mirrored coordinates
    logic [EXT_W-1:0]          cx_e, cy_e, x_e, y_e;
    logic [EXT_W-1:0]          xp_s, xm_s, yp_s, ym_s;

    assign ty_s   = $signed({r_y[Y_W-1], r_y}) - $signed((Y_W+1)'(1));
    assign ty_abs = ty_s[Y_W] ? (Y_W+1)'(-ty_s) : ty_s;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            MUL_NONE: ;
            MUL_RXRX: begin
                mul_a = MW'(r_rx);
                mul_b = MW'(r_rx);
            end
            MUL_RYRY: begin
                mul_a = MW'(r_ry);
                mul_b = MW'(r_ry);
            end
            MUL_RX2RY: begin
                mul_a = MW'(r_rx2);
                mul_b = MW'(r_ry);
            end
            MUL_TXTX: begin
                mul_a = MW'({r_x, 1'b1});
                mul_b = MW'({r_x, 1'b1});
            end
            MUL_TYTY: begin
                mul_a = MW'(ty_abs);
                mul_b = MW'(ty_abs);
            end
            MUL_RY2TA: begin
                mul_a = MW'(r_ry2);
                mul_b = r_ta;
            end
            MUL_RX2TB: begin
                mul_a = MW'(r_rx2);
                mul_b = r_tb;
            end
            MUL_RX2RY2: begin
                mul_a = MW'(r_rx2);
                mul_b = MW'(r_ry2);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign x_inc    = r_x + X_W'(1);
    assign y_dec    = r_y - $signed(Y_W'(1));
    assign two_ry2  = $signed(ST_W'({r_ry2, 1'b0}));
    assign two_rx2  = $signed(ST_W'({r_rx2, 1'b0}));
    assign sx_inc   = r_sx + two_ry2;
    assign sy_dec   = r_sy - two_rx2;
    assign sx_inc_e = DEC_W'(sx_inc);
    assign sy_dec_e = DEC_W'(sy_dec);
    assign rx2_e    = $signed(DEC_W'(r_rx2));
    assign ry2_e    = $signed(DEC_W'(r_ry2));
    assign prod_e   = $signed(DEC_W'(r_prod));
    // 4*ry^2 - 4*rx^2*ry + rx^2, product holds rx^2*ry
    assign init_dec = (ry2_e <<< 2) - (prod_e <<< 2) + rx2_e;
    assign step_last = r_region2 && y_dec[Y_W-1];

    always_comb begin
        n_rx2     = r_rx2;
        n_ry2     = r_ry2;
        n_ta      = r_ta;
        n_tb      = r_tb;
        n_x       = r_x;
        n_y       = r_y;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_dec     = r_dec;
        n_region2 = r_region2;
        n_busy    = r_busy;
        term      = '0;
        unique case (i_cmd.wb)
            WB_NONE: ;
            WB_RX2:  n_rx2 = r_prod[2*R-1:0];
            WB_RY2:  n_ry2 = r_prod[2*R-1:0];
            WB_INIT: begin
                n_x       = '0;
                n_y       = $signed(Y_W'(r_ry));
                n_sx      = '0;
                n_sy      = $signed(ST_W'({r_prod[3*R-1:0], 1'b0}));
                n_dec     = init_dec;
                n_region2 = 1'b0;
                n_busy    = 1'b1;
            end
            WB_TA:      n_ta = r_prod[MW-1:0];
            WB_TB:      n_tb = r_prod[MW-1:0];
            WB_DEC_SET: n_dec = prod_e;
            WB_DEC_ADD: n_dec = r_dec + (prod_e <<< 2);
            WB_DEC_SUB: begin
                n_dec     = r_dec - (prod_e <<< 2);
                n_region2 = 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.step_fire) begin
            if (!r_region2) begin
                n_x  = x_inc;
                n_sx = sx_inc;
                if (r_dec[DEC_W-1]) begin
                    term = sx_inc_e + ry2_e;
                end else begin
                    n_y  = y_dec;
                    n_sy = sy_dec;
                    term = sx_inc_e - sy_dec_e + ry2_e;
                end
            end else begin
                n_y  = y_dec;
                n_sy = sy_dec;
                if (!r_dec[DEC_W-1] && (r_dec != '0)) begin
                    term = rx2_e - sy_dec_e;
                end else begin
                    n_x  = x_inc;
                    n_sx = sx_inc;
                    term = sx_inc_e - sy_dec_e + rx2_e;
                end
            end
            n_dec = r_dec + (term <<< 2);
            if (step_last) n_busy = 1'b0;
        end
    end

    assign n_o_valid = i_cmd.step_fire ? 1'b1 : (i_ready ? 1'b0 : r_o_valid);

    assign cx_e = EXT_W'(r_cx);
    assign cy_e = EXT_W'(r_cy);
    assign x_e  = EXT_W'(r_x);
    assign y_e  = {{(EXT_W-Y_W){r_y[Y_W-1]}}, r_y};
    assign xp_s = cx_e + x_e;
    assign xm_s = cx_e - x_e;
    assign yp_s = cy_e + y_e;
    assign ym_s = cy_e - y_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region2 <= 1'b0;
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_region2 <= n_region2;
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_start) begin
            r_rx <= i_data[R-1:0];
            r_ry <= i_data[2*R-1:R];
            r_cx <= i_data[2*R+C-1:2*R];
            r_cy <= i_data[2*R+2*C-1:2*R+C];
        end
        r_prod <= mul_p;
        r_rx2  <= n_rx2;
        r_ry2  <= n_ry2;
        r_ta   <= n_ta;
        r_tb   <= n_tb;
        r_x    <= n_x;
        r_y    <= n_y;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_dec  <= n_dec;
        if (i_cmd.step_fire) begin
            r_o_data <= OUT_TD_W'({ym_s[OUT_W-1:0], yp_s[OUT_W-1:0],
                                   xm_s[OUT_W-1:0], xp_s[OUT_W-1:0]});
            r_o_last <= step_last;
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.need_rc  = !r_region2 && (r_sx >= r_sy);
    assign o_status.out_free = !r_o_valid || i_ready;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

    `MER_ASSERT_NEXT(a_init_arms_region_one, i_clk, i_rst_n, i_cmd.wb == WB_INIT, r_busy && !r_region2)
    `MER_ASSERT_NEXT(a_step_loads_result, i_clk, i_rst_n, i_cmd.step_fire, r_o_valid)

endmodule

`default_nettype wire

// File: rtl/midpoint_ellipse_raster.sv
// top level of the midpoint ellipse rasterizer
//
//  channel   dir  handshake              payload
//  s side    in   i_s_tvalid/o_s_tready  tdata: radius_x, radius_y, center_x, center_y
//                                        tuser: kind (0 start, 1 step)
//  m side    out  o_m_tvalid/i_m_tready  tdata: x_plus, x_minus, y_plus, y_minus
//                                        tlast: last point group of the ellipse
//
// a start item: accept, then squares and rx^2*ry on the shared multiplier
// a step item: accept, then one decision update into the result register (a step while idle is dropped)
// the first step past the slope crossover first forms the region-2 decision products
// a step waits in its update cycle while the result register is full and not taken
// reset clears control state only; no clearing pass
`default_nettype none

module midpoint_ellipse_raster
    import mer_pkg::*;
#(
    parameter  int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter  int COORD_BITS  = COORD_BITS_DEF,
    localparam int IN_TD_W     = ((2 * RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TD_W    = ((4 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // radius_x, radius_y, center_x, center_y, zero pad
    input  wire logic [IN_TD_W-1:0]  i_s_tdata,
    // kind
    input  wire logic                i_s_tuser,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // x_plus, x_minus, y_plus, y_minus, zero pad
    output logic [OUT_TD_W-1:0]      o_m_tdata,
    output logic                     o_m_tlast
);

    t_cmd    cmd;
    t_status status;

    mer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_kind   (i_s_tuser),
        .o_ready  (o_s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_s_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule

`default_nettype wire

// File: test/midpoint_ellipse_raster_tb.sv
// self-checking testbench of the midpoint ellipse rasterizer
`timescale 1ns / 100ps

module midpoint_ellipse_raster_tb;
    import mer_pkg::*;

    localparam int RB    = RADIUS_BITS_DEF;
    localparam int CB    = COORD_BITS_DEF;
    localparam int OB    = CB + 2;
    localparam int IN_W  = ((2 * RB + 2 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((4 * OB + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        logic          kind;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        int            phase;
        bit            hold_rx;
        bit            drain;
    } raster_item_t;

    // one point group as it appears on {tlast, tdata}
    typedef struct packed {
        logic          last;
        logic [OB-1:0] y_minus;
        logic [OB-1:0] y_plus;
        logic [OB-1:0] x_minus;
        logic [OB-1:0] x_plus;
    } point_group_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // radius_x, radius_y, center_x, center_y, zero pad
    logic [IN_W-1:0]  i_s_tdata = '0;
    // kind
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    // x_plus, x_minus, y_plus, y_minus
    logic [OUT_W-1:0] o_m_tdata;
    logic             o_m_tlast;

    midpoint_ellipse_raster dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    raster_item_t pending_items[$];
    point_group_t expected_points[$];
    int           err_count = 0;
    int           cur_phase = 0;
    logic         hold_start = 1'b0;
    int           hold_left = 0;

    // phases: no idling, sender idle, receiver stalling, both
    int send_idle_pct[4]  = '{0, 85, 0, 12};
    int recv_stall_pct[4] = '{0, 0, 85, 12};

    // tracer state, decision terms kept four times the textbook value
    longint off_x, off_y, slope_x, slope_y, dec_term;
    longint held_rx, held_ry, held_cx, held_cy;
    bit     region_two = 1'b0;
    bit     tracing = 1'b0;

    function automatic void trace_ellipse(raster_item_t it);
        longint rx2, ry2, tx, ty;
        point_group_t p;
        if (it.kind == KIND_START) begin
            held_rx = longint'(it.rx);
            held_ry = longint'(it.ry);
            held_cx = longint'(it.cx);
            held_cy = longint'(it.cy);
            rx2 = held_rx * held_rx;
            ry2 = held_ry * held_ry;
            off_x = 0;
            off_y = held_ry;
            slope_x = 0;
            slope_y = 2 * rx2 * off_y;
            dec_term = 4 * ry2 - 4 * rx2 * held_ry + rx2;
            region_two = 1'b0;
            tracing = 1'b1;
            return;
        end
        if (!tracing)
            return;
        rx2 = held_rx * held_rx;
        ry2 = held_ry * held_ry;
        if (!region_two && slope_x >= slope_y) begin
            tx = 2 * off_x + 1;
            ty = off_y - 1;
            dec_term = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
            region_two = 1'b1;
        end
        p.x_plus  = OB'(held_cx + off_x);
        p.x_minus = OB'(held_cx - off_x);
        p.y_plus  = OB'(held_cy + off_y);
        p.y_minus = OB'(held_cy - off_y);
        p.last    = 1'b0;
        if (!region_two) begin
            off_x += 1;
            slope_x += 2 * ry2;
            if (dec_term < 0) begin
                dec_term += 4 * (slope_x + ry2);
            end else begin
                off_y -= 1;
                slope_y -= 2 * rx2;
                dec_term += 4 * (slope_x - slope_y + ry2);
            end
        end else begin
            off_y -= 1;
            slope_y -= 2 * rx2;
            if (dec_term > 0) begin
                dec_term += 4 * (rx2 - slope_y);
            end else begin
                off_x += 1;
                slope_x += 2 * ry2;
                dec_term += 4 * (slope_x - slope_y + rx2);
            end
            if (off_y < 0) begin
                p.last = 1'b1;
                tracing = 1'b0;
            end
        end
        expected_points.push_back(p);
    endfunction

    task automatic add_item(logic kind, int rx, int ry, int cx, int cy, int phase,
                            bit hold_rx, bit drain);
        raster_item_t it;
        it.kind = kind;
        it.rx = RB'(rx);
        it.ry = RB'(ry);
        it.cx = CB'(cx);
        it.cy = CB'(cy);
        it.phase = phase;
        it.hold_rx = hold_rx;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    // start item followed by step items; hold marks the first step
    task automatic add_ellipse(int rx, int ry, int cx, int cy, int steps, int phase,
                               bit drain, bit hold);
        add_item(KIND_START, rx, ry, cx, cy, phase, 1'b0, drain);
        for (int i = 0; i < steps; i++)
            add_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom, phase,
                     hold && i == 0, 1'b0);
    endtask

    function automatic int pick_center();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        else if (r < 20)
            return (1 << CB) - 1;
        return $urandom_range((1 << CB) - 1);
    endfunction

    // sender
    always @(posedge i_clk) begin : driver_proc
        raster_item_t front;
        bit accepted;
        bit hold_now;
        hold_now = 1'b0;
        if (i_rst_n) begin
            accepted = i_s_tvalid && o_s_tready;
            if (accepted) begin
                trace_ellipse(pending_items[0]);
                hold_now = pending_items[0].hold_rx;
                pending_items.pop_front();
            end
            if (!(i_s_tvalid && !accepted)) begin
                if (pending_items.size() != 0) begin
                    front = pending_items[0];
                    if ((!front.drain || expected_points.size() == 0) &&
                        $urandom_range(99) >= send_idle_pct[front.phase]) begin
                        i_s_tvalid <= 1'b1;
                        i_s_tdata  <= {{(IN_W - 2 * RB - 2 * CB){1'b0}},
                                       front.cy, front.cx, front.ry, front.rx};
                        i_s_tuser  <= front.kind;
                        cur_phase  <= front.phase;
                    end else begin
                        i_s_tvalid <= 1'b0;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
        hold_start <= hold_now;
    end

    // long receiver hold-off, armed by the flagged item
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver and checker
    always @(posedge i_clk) begin : monitor_proc
        point_group_t got;
        point_group_t want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tlast, o_m_tdata[4*OB-1:0]};
                if (expected_points.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected item xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                             $time, $signed(got.x_plus), $signed(got.x_minus),
                             $signed(got.y_plus), $signed(got.y_minus), got.last);
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        err_count++;
                        $display("%0t: mismatch expected xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                                 $time, $signed(want.x_plus), $signed(want.x_minus),
                                 $signed(want.y_plus), $signed(want.y_minus), want.last);
                        $display("%0t:          actual   xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
                                 $time, $signed(got.x_plus), $signed(got.x_minus),
                                 $signed(got.y_plus), $signed(got.y_minus), got.last);
                    end
                end
            end
            i_m_tready <= (hold_left == 0) &&
                          ($urandom_range(99) >= recv_stall_pct[cur_phase]);
        end
    end

    initial begin
        int count;
        int rx, ry, steps, phase, r;
        bit drained;
        // directed: idle step, zero radii, extremes, restart while busy
        add_item(KIND_STEP, 1023, 1023, 4095, 4095, 3, 1'b0, 1'b0);
        add_ellipse(0, 0, 0, 0, 2, 3, 1'b0, 1'b0);
        add_ellipse(1023, 0, 4095, 4095, 1, 3, 1'b0, 1'b0);
        add_ellipse(0, 3, 100, 5, 4, 3, 1'b0, 1'b0);
        add_ellipse(1023, 1023, 0, 4095, 3, 3, 1'b0, 1'b0);
        add_ellipse(5, 3, 4095, 0, 10, 3, 1'b0, 1'b0);

        // receiver held off while the sender keeps offering steps
        add_ellipse(40, 30, 2000, 2000, 71, 0, 1'b0, 1'b1);

        count = 0;
        drained = 1'b0;
        while (count < RANDOM_ITEMS) begin
            phase = (count * 4) / RANDOM_ITEMS;
            r = $urandom_range(99);
            if (r < 75) begin
                rx = $urandom_range(12);
                ry = $urandom_range(12);
            end else if (r < 92) begin
                rx = $urandom_range(60);
                ry = $urandom_range(60);
            end else begin
                rx = $urandom_range((1 << RB) - 1);
                ry = $urandom_range((1 << RB) - 1);
            end
            if (r >= 92)
                steps = $urandom_range(1, 8);
            else if ($urandom_range(99) < 10)
                steps = $urandom_range(rx + ry + 1);
            else
                steps = rx + ry + 1;
            // a single step item now and then, ahead of the next start
            if ($urandom_range(99) < 5)
                add_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom, phase,
                         1'b0, 1'b0);
            add_ellipse(rx, ry, pick_center(), pick_center(), steps, phase,
                        !drained && count >= RANDOM_ITEMS / 2, 1'b0);
            if (count >= RANDOM_ITEMS / 2)
                drained = 1'b1;
            count += 1 + steps;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_s_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_datapath.sv
rtl/midpoint_ellipse_raster.sv
test/midpoint_ellipse_raster_tb.sv
